>>> rtl/core/mto_pkg.sv
// Shared constants and types of the mask tint overlay block.
package mto_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_TINT_RED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OPACITY       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_BOUNDARY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd6;

    localparam logic [7:0]  RST_TINT_RED   = 8'd255;
    localparam logic [7:0]  RST_TINT_GREEN = 8'd0;
    localparam logic [7:0]  RST_TINT_BLUE  = 8'd0;
    localparam logic [7:0]  RST_OPACITY    = 8'd128;
    localparam logic [12:0] RST_DIM        = 13'd4096;

    localparam logic [15:0] FULL_WEIGHT = 16'd65025;

    localparam logic [7:0] YELLOW_RED   = 8'd255;
    localparam logic [7:0] YELLOW_GREEN = 8'd255;
    localparam logic [7:0] YELLOW_BLUE  = 8'd0;

    localparam logic [8:0] WINDOW_ALL_SET = 9'h1FF;

    typedef struct packed {
        logic       nz;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_entry;

    // command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

endpackage

>>> rtl/core/mto_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module mto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mto_blend.sv
// One color lane of the tint blend: four register stages, exact divide by 65025.
module mto_blend import mto_pkg::*; (
    input  logic        i_clk,
    input  logic [7:0]  i_chan,
    input  logic [7:0]  i_tint,
    input  logic [15:0] i_weight,
    output logic [7:0]  o_value
);

    logic [23:0] r_pa;
    logic [23:0] r_pb;
    logic [24:0] r_num;
    logic [16:0] r_est;
    logic [15:0] r_quo1;
    logic [7:0]  r_quo;

    logic [24:0] sum;
    logic [24:0] est_sum;
    logic [24:0] rem1;
    logic [16:0] quo1_w;
    logic [16:0] est2_sum;
    logic [8:0]  est2;
    logic [16:0] rem2;
    logic [8:0]  quo_w;

    always_comb begin
        sum     = 25'(r_pa) + 25'(r_pb);
        // x/255 from below: x/256 * (1 + 1/256 + 1/65536), at most one short
        est_sum = sum + (sum >> 8) + (sum >> 16);
        rem1    = r_num - 25'(r_est) * 25'd255;
        quo1_w  = r_est + ((rem1 >= 25'd255) ? 17'd1 : 17'd0);
        est2_sum = 17'(r_quo1) + 17'(r_quo1 >> 8);
        est2    = est2_sum[16:8];
        rem2    = 17'(r_quo1) - 17'(est2) * 17'd255;
        quo_w   = est2 + ((rem2 >= 17'd255) ? 9'd1 : 9'd0);
    end

    always_ff @(posedge i_clk) begin
        r_pa   <= 24'(i_chan) * 24'(FULL_WEIGHT - i_weight);
        r_pb   <= 24'(i_tint) * 24'(i_weight);
        r_num  <= sum;
        r_est  <= est_sum[24:8];
        r_quo1 <= quo1_w[15:0];
        r_quo  <= quo_w[7:0];
    end

    assign o_value = r_quo;

endmodule

>>> rtl/core/mask_tint_overlay_with_outline.sv
// A pixel beat passes through acceptance, four blend stages (the CALC state) and write-back;
// a drain beat goes from acceptance straight to write-back. A result shows on the output in
// the cycle after write-back. A new beat is taken only once the last one is written back, and
// a write-back that emits waits while a held result is not taken. A pixel result leaves width+1
// pixels later. Reset (synchronous, active low) clears the sequencer, counters and output valid
// and loads the configuration defaults; payload registers and memories are not cleared.
module mask_tint_overlay_with_outline import mto_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_command,
    input  logic [7:0]            i_base_red,
    input  logic [7:0]            i_base_green,
    input  logic [7:0]            i_base_blue,
    input  logic [7:0]            i_mask_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic                  o_is_outline,
    output logic                  o_frame_last
);

    localparam int FIFO_DEPTH = MAX_WIDTH + 1;
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int NW = $clog2(FIFO_DEPTH + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int EW = $bits(t_entry);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WB   = 2'd2;

    // configuration
    logic [7:0]  r_tint_red, r_tint_green, r_tint_blue, r_opacity;
    logic        r_draw;
    logic [12:0] r_width, r_height;

    // sequencer and latched beat
    logic [1:0]  r_state, n_state;
    logic [1:0]  r_step, n_step;
    logic        r_cmd;
    logic [7:0]  r_red, r_green, r_blue;
    logic        r_nz;
    logic [15:0] r_wt;

    // stream state
    logic [8:0]    r_window, n_window;
    logic [CW-1:0] r_in_col, n_in_col;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [RW-1:0] r_out_row, n_out_row;
    logic [NW-1:0] r_count, n_count;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_red, r_out_green, r_out_blue;
    logic          r_out_outline, r_out_last;

    logic [7:0]  q_red, q_green, q_blue;
    t_entry      fifo_q, fifo_wdata;
    logic [1:0]  flag_q;
    logic        accept, cfg_we, geom_we;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic        emit_px, emit_dr, emit, stall, go, interior, outline, last;
    logic [8:0]  win_new;
    logic        fifo_we, flag_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign geom_we     = cfg_we && (i_cfg_index == REG_IMAGE_WIDTH ||
                                    i_cfg_index == REG_IMAGE_HEIGHT);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        if (r_width == 13'd0) begin
            w_eff = WW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        if (r_height == 13'd0) begin
            h_eff = HW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_height);
        end
    end

    mto_blend u_blend_red (
        .i_clk(i_clk), .i_chan(r_red), .i_tint(r_tint_red), .i_weight(r_wt), .o_value(q_red)
    );
    mto_blend u_blend_green (
        .i_clk(i_clk), .i_chan(r_green), .i_tint(r_tint_green), .i_weight(r_wt),
        .o_value(q_green)
    );
    mto_blend u_blend_blue (
        .i_clk(i_clk), .i_chan(r_blue), .i_tint(r_tint_blue), .i_weight(r_wt),
        .o_value(q_blue)
    );

    assign fifo_wdata = '{nz: r_nz, blue: q_blue, green: q_green, red: q_red};

    mto_ram #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_delay_ram (
        .i_clk(i_clk), .i_we(fifo_we), .i_waddr(r_wr_ptr), .i_wdata(fifo_wdata),
        .i_re(accept), .i_raddr(r_rd_ptr), .o_rdata(fifo_q)
    );

    // flag memory: bit 1 row above, bit 0 current-minus-one row
    mto_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_flag_ram (
        .i_clk(i_clk), .i_we(flag_we), .i_waddr(r_in_col), .i_wdata({flag_q[0], r_nz}),
        .i_re(accept), .i_raddr(r_in_col), .o_rdata(flag_q)
    );

    always_comb begin
        emit_px  = (r_cmd == CMD_PIXEL) && (32'(r_count) == 32'(w_eff) + 32'd1);
        emit_dr  = (r_cmd == CMD_DRAIN) && (r_count != '0);
        emit     = emit_px || emit_dr;
        stall    = emit && r_out_valid && !i_out_ready;
        go       = (r_state == ST_WB) && !stall;
        win_new  = {r_window[5:0], r_nz, flag_q[0], flag_q[1]};
        interior = (r_out_row != '0) && (32'(r_out_row) + 32'd1 < 32'(h_eff)) &&
                   (r_out_col != '0) && (32'(r_out_col) + 32'd1 < 32'(w_eff));
        outline  = emit_px && r_draw && interior && fifo_q.nz && (win_new != WINDOW_ALL_SET);
        last     = (32'(r_out_row) + 32'd1 >= 32'(h_eff)) &&
                   (32'(r_out_col) + 32'd1 >= 32'(w_eff));
        fifo_we  = go && (r_cmd == CMD_PIXEL);
        flag_we  = fifo_we;
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_window    = r_window;
        n_in_col    = r_in_col;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_count     = r_count;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_step  = '0;
                    n_state = (i_command == CMD_DRAIN) ? ST_WB : ST_CALC;
                end
            end
            ST_CALC: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (go) begin
                    n_state = ST_IDLE;
                    if (r_cmd == CMD_PIXEL) begin
                        n_window = win_new;
                        n_wr_ptr = (32'(r_wr_ptr) == 32'(MAX_WIDTH)) ? '0 : r_wr_ptr + 1'b1;
                        n_in_col = (32'(r_in_col) + 32'd1 >= 32'(w_eff)) ? '0 : r_in_col + 1'b1;
                        if (!emit_px) begin
                            n_count = r_count + 1'b1;
                        end
                    end else if (emit_dr) begin
                        n_count = r_count - 1'b1;
                    end
                    if (emit) begin
                        n_out_valid = 1'b1;
                        n_rd_ptr = (32'(r_rd_ptr) == 32'(MAX_WIDTH)) ? '0 : r_rd_ptr + 1'b1;
                        if (32'(r_out_col) + 32'd1 >= 32'(w_eff)) begin
                            n_out_col = '0;
                            n_out_row = (32'(r_out_row) + 32'd1 >= 32'(h_eff)) ?
                                        '0 : r_out_row + 1'b1;
                        end else begin
                            n_out_col = r_out_col + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // geometry change drops every pixel held in the delay line and restarts the stream position
        if (geom_we) begin
            n_window  = '0;
            n_in_col  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_count   = '0;
            n_rd_ptr  = '0;
            n_wr_ptr  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_window     <= '0;
            r_in_col     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_count      <= '0;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_out_valid  <= 1'b0;
            r_tint_red   <= RST_TINT_RED;
            r_tint_green <= RST_TINT_GREEN;
            r_tint_blue  <= RST_TINT_BLUE;
            r_opacity    <= RST_OPACITY;
            r_draw       <= 1'b0;
            r_width      <= RST_DIM;
            r_height     <= RST_DIM;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_window    <= n_window;
            r_in_col    <= n_in_col;
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
            r_count     <= n_count;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_out_valid <= n_out_valid;
            if (cfg_we) begin
                case (i_cfg_index)
                    REG_TINT_RED:      r_tint_red   <= i_cfg_data[7:0];
                    REG_TINT_GREEN:    r_tint_green <= i_cfg_data[7:0];
                    REG_TINT_BLUE:     r_tint_blue  <= i_cfg_data[7:0];
                    REG_OPACITY:       r_opacity    <= i_cfg_data[7:0];
                    REG_DRAW_BOUNDARY: r_draw       <= i_cfg_data[0];
                    REG_IMAGE_WIDTH:   r_width      <= i_cfg_data;
                    REG_IMAGE_HEIGHT:  r_height     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_command;
            r_red   <= i_base_red;
            r_green <= i_base_green;
            r_blue  <= i_base_blue;
            r_nz    <= (i_mask_value != 8'd0);
            r_wt    <= 16'(r_opacity) * 16'(i_mask_value);
        end
        if (go && emit) begin
            r_out_outline <= outline;
            r_out_last    <= last;
            if (outline) begin
                r_out_red   <= YELLOW_RED;
                r_out_green <= YELLOW_GREEN;
                r_out_blue  <= YELLOW_BLUE;
            end else begin
                r_out_red   <= fifo_q.red;
                r_out_green <= fifo_q.green;
                r_out_blue  <= fifo_q.blue;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out_red;
    assign o_out_green  = r_out_green;
    assign o_out_blue   = r_out_blue;
    assign o_is_outline = r_out_outline;
    assign o_frame_last = r_out_last;

endmodule

>>> rtl/core/mto_check.sv
// Port-level checker for the mask tint overlay block, bound to the top level.
module mto_check import mto_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [7:0]            o_out_red,
    input logic [7:0]            o_out_green,
    input logic [7:0]            o_out_blue,
    input logic                  o_is_outline
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before its beat");

    a_outline_yellow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_outline |->
            o_out_red == YELLOW_RED && o_out_green == YELLOW_GREEN &&
            o_out_blue == YELLOW_BLUE)
        else $error("outline result not yellow");

    // one beat in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

endmodule

bind mask_tint_overlay_with_outline mto_check u_mto_check (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_red(o_out_red),
    .o_out_green(o_out_green), .o_out_blue(o_out_blue), .o_is_outline(o_is_outline)
);

>>> dv/mask_tint_overlay_with_outline_tb.sv
// Self-checking mask tint overlay testbench: a directed table, register extremes, random frames.
module mask_tint_overlay_with_outline_tb;
    import mto_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = DEF_MAX_WIDTH;
    localparam int MAXH = DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       outline;
        logic       last;
    } t_pixel_out;

    typedef struct {
        logic       cmd;
        logic [7:0] r, g, b, m;
        logic       has_lit;
        t_pixel_out lit;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_command = CMD_PIXEL;
    logic [7:0] i_base_red = '0, i_base_green = '0, i_base_blue = '0, i_mask_value = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [7:0] o_out_red, o_out_green, o_out_blue;
    logic o_is_outline, o_frame_last;

    mask_tint_overlay_with_outline dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  tint_r, tint_g, tint_b, opac;
    logic        boundary_on;
    logic [12:0] width_reg, height_reg;
    t_entry      delay_line [MAXW+1];
    logic        upper_flags [MAXW];
    logic        middle_flags [MAXW];
    logic [8:0]  window;
    int          in_col, in_row, out_col, out_row, held;

    t_pixel_out  expected_pixels [$];
    t_pixel_out  literal_q [$];
    logic        literal_used [$];
    int          failures = 0;
    int          cycles = 0;
    logic        long_stall = 1'b0;

    function automatic int dim_of(logic [12:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic logic [7:0] mix(logic [7:0] c, logic [7:0] t, int w);
        return 8'((int'(c) * (65025 - w) + int'(t) * w) / 65025);
    endfunction

    task automatic clear_position();
        window = '0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; held = 0;
    endtask

    task automatic reset_predictor();
        tint_r = RST_TINT_RED; tint_g = RST_TINT_GREEN; tint_b = RST_TINT_BLUE;
        opac = RST_OPACITY; boundary_on = 1'b0;
        width_reg = RST_DIM; height_reg = RST_DIM;
        clear_position();
    endtask

    function automatic t_pixel_out release_pixel(t_entry e, logic allow);
        t_pixel_out p;
        int w, h;
        logic inner;
        w = dim_of(width_reg, MAXW);
        h = dim_of(height_reg, MAXH);
        inner = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
        if (allow && boundary_on && inner && e.nz && window != WINDOW_ALL_SET) begin
            p.red = YELLOW_RED; p.green = YELLOW_GREEN; p.blue = YELLOW_BLUE; p.outline = 1'b1;
        end else begin
            p.red = e.red; p.green = e.green; p.blue = e.blue; p.outline = 1'b0;
        end
        p.last = (out_row + 1 >= h) && (out_col + 1 >= w);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
            if (out_row >= h) out_row = 0;
        end
        return p;
    endfunction

    // returns 1 when the beat yields a pixel
    function automatic logic overlay_step(logic cmd, logic [7:0] r, g, b, m,
                                          output t_pixel_out p);
        int w, h, wt, col;
        t_entry e;
        logic top, mid, bot, made;
        w = dim_of(width_reg, MAXW);
        h = dim_of(height_reg, MAXH);
        made = 1'b0;
        if (cmd == CMD_DRAIN) begin
            if (held == 0) return 1'b0;
            held--;
            p = release_pixel(delay_line[held], 1'b0);
            return 1'b1;
        end
        wt = int'(opac) * int'(m);
        e.red = mix(r, tint_r, wt);
        e.green = mix(g, tint_g, wt);
        e.blue = mix(b, tint_b, wt);
        e.nz = m != 0;
        col = in_col < MAXW ? in_col : MAXW - 1;
        top = upper_flags[col];
        mid = middle_flags[col];
        bot = m != 0;
        window = {window[5:0], bot, mid, top};
        upper_flags[col] = mid;
        middle_flags[col] = bot;
        if (held > w + 1) held = w + 1;
        if (held == w + 1) begin
            p = release_pixel(delay_line[w], 1'b1);
            made = 1'b1;
            held--;
        end
        for (int i = held; i > 0; i--) delay_line[i] = delay_line[i-1];
        delay_line[0] = e;
        held++;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_row = 0;
        end
        return made;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_TINT_RED:      tint_r = val[7:0];
            REG_TINT_GREEN:    tint_g = val[7:0];
            REG_TINT_BLUE:     tint_b = val[7:0];
            REG_OPACITY:       opac = val[7:0];
            REG_DRAW_BOUNDARY: boundary_on = val[0];
            REG_IMAGE_WIDTH:   begin width_reg = val; clear_position(); end
            REG_IMAGE_HEIGHT:  begin height_reg = val; clear_position(); end
            default: ;
        endcase
    endtask

    // hold until every pixel has come out, then let the pipeline settle
    task automatic settle();
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // one beat; a literal, if given, must agree with the predictor too
    task automatic send(logic cmd, logic [7:0] r, g, b, m, logic has_lit = 1'b0,
                        t_pixel_out lit = '0);
        t_pixel_out p;
        i_command <= cmd;
        i_base_red <= r; i_base_green <= g; i_base_blue <= b; i_mask_value <= m;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (overlay_step(cmd, r, g, b, m, p)) begin
            expected_pixels.push_back(p);
            literal_q.push_back(lit);
            literal_used.push_back(has_lit);
        end
    endtask

    task automatic idle(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_all();
        while (held > 0)
            send(CMD_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        i_in_valid <= 1'b0;
    endtask

    // receiver: random stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else if (long_stall) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(0, 3) != 0) || cycles[9];
    end

    always @(posedge i_clk) begin
        t_pixel_out want, got, lit;
        logic use_lit;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_out_red, o_out_green, o_out_blue, o_is_outline, o_frame_last};
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel %h", $time, got);
                failures++;
            end else begin
                want = expected_pixels.pop_front();
                lit = literal_q.pop_front();
                use_lit = literal_used.pop_front();
                if (use_lit && lit != want) begin
                    $display("%0t: table row expected %h, predictor %h", $time, lit, want);
                    failures++;
                end
                if (got.red != want.red || got.green != want.green || got.blue != want.blue
                    || got.outline != want.outline || got.last != want.last) begin
                    $display("%0t: expected %h actual %h", $time, want, got);
                    failures++;
                end
            end
        end
    end

    t_row dir_rows [$];

    initial begin
        int w, h, n, burst;
        t_row row;
        reset_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 3x3 frame, reset tint (red, opacity 128), boundary on
        write_reg(REG_DRAW_BOUNDARY, 13'd1);
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        dir_rows.push_back('{CMD_DRAIN, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0}); // nothing held
        dir_rows.push_back('{CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0});
        dir_rows.push_back('{CMD_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, '0});
        dir_rows.push_back('{CMD_PIXEL, 8'd1, 8'd2, 8'd3, 8'd128, 1'b0, '0});
        // the second of these pushes out the top-left corner: unmasked black
        for (int i = 0; i < 6; i++)
            dir_rows.push_back('{CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                                 (i == 1 ? 8'd0 : 8'd255), (i == 1), '0});
        dir_rows.push_back('{CMD_PIXEL, 8'd9, 8'd9, 8'd9, 8'd9, 1'b0, '0});
        for (int i = 0; i < 4; i++)
            dir_rows.push_back('{CMD_DRAIN, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, '0});
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send(row.cmd, row.r, row.g, row.b, row.m, row.has_lit, row.lit);
        end
        drain_all();
        settle();

        // tint, opacity and geometry registers at their extremes, out-of-range geometry too
        write_reg(REG_TINT_RED, 13'd0);
        write_reg(REG_TINT_GREEN, 13'd255);
        write_reg(REG_TINT_BLUE, 13'h1FFF);
        write_reg(REG_OPACITY, 13'd255);
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        for (int i = 0; i < 6; i++) send(CMD_PIXEL, 8'd255, 8'd0, 8'd128, 8'd255);
        drain_all();
        settle();

        // random phases of small frames
        for (int phase = 0; phase < 12; phase++) begin
            write_reg(REG_TINT_RED, 13'($urandom));
            write_reg(REG_TINT_GREEN, 13'($urandom));
            write_reg(REG_TINT_BLUE, 13'($urandom));
            write_reg(REG_OPACITY, phase == 1 ? 13'd0 : 13'($urandom));
            write_reg(REG_DRAW_BOUNDARY, 13'(phase != 2));
            w = (phase == 3) ? 1 : $urandom_range(3, 12);
            h = (phase == 4) ? 2 : $urandom_range(3, 10);
            write_reg(REG_IMAGE_WIDTH, 13'(w));
            write_reg(REG_IMAGE_HEIGHT, 13'(h));
            n = 0;
            while (n < 125) begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst; k++) begin
                    // masks mostly nonzero so that outlines appear
                    send(($urandom_range(0, 40) == 0) ? CMD_DRAIN : CMD_PIXEL,
                         8'($urandom), 8'($urandom), 8'($urandom),
                         ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom));
                    n++;
                end
                if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 8));
                if (phase == 5 && n >= 60 && n < 80) begin
                    // long receiver hold-off while input keeps coming
                    long_stall <= 1'b1;
                    fork
                        begin repeat (400) @(posedge i_clk); long_stall <= 1'b0; end
                        for (int k = 0; k < 40; k++)
                            send(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom));
                    join
                    n += 40;
                end
                if (phase == 6 && n >= 60 && n < 80) begin
                    idle(1);
                    while (expected_pixels.size() != 0) @(posedge i_clk);
                end
            end
            if (phase % 3 != 0) drain_all();
            else i_in_valid <= 1'b0;
            settle();
        end

        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
